// ===== rtl/core/accumulator_alu_with_flags_defines.svh =====
// Assertion macros shared by the ALU block.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AAWF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define AAWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/aawf_pkg.sv =====
package aawf_pkg;

    // Operation codes; code 15 is a pass-through.
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_ADC  = 4'd1,
        OP_SUB  = 4'd2,
        OP_SBC  = 4'd3,
        OP_AND  = 4'd4,
        OP_XOR  = 4'd5,
        OP_OR   = 4'd6,
        OP_CP   = 4'd7,
        OP_INC  = 4'd8,
        OP_DEC  = 4'd9,
        OP_DAA  = 4'd10,
        OP_RLC  = 4'd11,
        OP_RRC  = 4'd12,
        OP_RL   = 4'd13,
        OP_RR   = 4'd14,
        OP_PASS = 4'd15
    } t_op;

    // Decimal adjust constants.
    localparam logic [7:0] BCD_MAX    = 8'h99;
    localparam logic [7:0] BCD_HI_ADJ = 8'h60;
    localparam logic [7:0] BCD_LO_ADJ = 8'h06;
    localparam logic [3:0] DIGIT_MAX  = 4'h9;
    localparam logic [3:0] NIBBLE_ALL = 4'hF;

    // Flag group.
    typedef struct packed {
        logic zero;
        logic subtract;
        logic half;
        logic carry;
    } t_flags;

    // One operation word.
    typedef struct packed {
        logic [3:0] op;
        logic [7:0] a_value;
        logic [7:0] b_value;
        t_flags     flags;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [7:0] result;
        t_flags     flags;
    } t_out_word;

endpackage

// ===== rtl/core/aawf_in_stage.sv =====
module aawf_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  aawf_pkg::t_in_word i_word,
    input  logic              i_advance,
    output logic              o_stall,
    output logic              o_valid,
    output aawf_pkg::t_in_word o_word
);

    logic               r_valid;
    logic               n_valid;
    aawf_pkg::t_in_word r_word;
    logic               w_take;

    // Hold the word while the result stage cannot take it.
    assign o_stall = r_valid && !i_advance;
    assign w_take  = i_valid && !o_stall;

    // Next valid: load on accept, drop once moved on.
    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the operand word.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/core/aawf_alu.sv =====
module aawf_alu (
    input  aawf_pkg::t_in_word  i_word,
    output aawf_pkg::t_out_word o_word
);

    logic [7:0]       w_a;
    logic [7:0]       w_b;
    aawf_pkg::t_flags w_fi;
    logic             w_cin_add;
    logic             w_cin_sub;
    logic [8:0]       w_sum;
    logic [4:0]       w_sum_lo;
    logic [8:0]       w_diff;
    logic [4:0]       w_diff_lo;
    logic [7:0]       w_inc;
    logic [7:0]       w_dec;
    logic             w_daa_hi;
    logic             w_daa_lo;
    logic [7:0]       w_daa_adj;
    logic [7:0]       w_daa;
    logic [7:0]       w_val;
    logic [7:0]       w_res;
    aawf_pkg::t_flags w_fo;

    assign w_a  = i_word.a_value;
    assign w_b  = i_word.b_value;
    assign w_fi = i_word.flags;

    // Carry enters only for the with-carry forms.
    assign w_cin_add = (i_word.op == aawf_pkg::OP_ADC) && w_fi.carry;
    assign w_cin_sub = (i_word.op == aawf_pkg::OP_SBC) && w_fi.carry;

    // Adder and subtractor with nibble taps for half-carry.
    assign w_sum     = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_cin_add};
    assign w_sum_lo  = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_cin_add};
    assign w_diff    = {1'b0, w_a} - {1'b0, w_b} - {8'd0, w_cin_sub};
    assign w_diff_lo = {1'b0, w_a[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_cin_sub};
    assign w_inc     = w_a + 8'd1;
    assign w_dec     = w_a - 8'd1;

    // Decimal adjust: corrections tested on the original byte.
    always_comb begin
        if (!w_fi.subtract) begin
            w_daa_hi = w_fi.carry || (w_a > aawf_pkg::BCD_MAX);
            w_daa_lo = w_fi.half || (w_a[3:0] > aawf_pkg::DIGIT_MAX);
        end else begin
            w_daa_hi = w_fi.carry;
            w_daa_lo = w_fi.half;
        end
        w_daa_adj = (w_daa_hi ? aawf_pkg::BCD_HI_ADJ : 8'd0)
                  | (w_daa_lo ? aawf_pkg::BCD_LO_ADJ : 8'd0);
        w_daa     = w_fi.subtract ? (w_a - w_daa_adj) : (w_a + w_daa_adj);
    end

    // Select the value, flags and result byte per operation.
    always_comb begin
        w_val = w_a;
        w_res = w_a;
        w_fo  = w_fi;
        case (i_word.op)
            aawf_pkg::OP_ADD, aawf_pkg::OP_ADC: begin
                w_val = w_sum[7:0];
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: w_sum_lo[4], carry: w_sum[8]};
            end
            aawf_pkg::OP_SUB, aawf_pkg::OP_SBC, aawf_pkg::OP_CP: begin
                w_val = w_diff[7:0];
                w_fo  = '{zero: 1'b0, subtract: 1'b1, half: w_diff_lo[4], carry: w_diff[8]};
            end
            aawf_pkg::OP_AND: begin
                w_val = w_a & w_b;
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b1, carry: 1'b0};
            end
            aawf_pkg::OP_XOR: begin
                w_val = w_a ^ w_b;
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: 1'b0};
            end
            aawf_pkg::OP_OR: begin
                w_val = w_a | w_b;
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: 1'b0};
            end
            aawf_pkg::OP_INC: begin
                w_val = w_inc;
                w_fo  = '{zero: 1'b0, subtract: 1'b0,
                          half: (w_a[3:0] == aawf_pkg::NIBBLE_ALL), carry: w_fi.carry};
            end
            aawf_pkg::OP_DEC: begin
                w_val = w_dec;
                w_fo  = '{zero: 1'b0, subtract: 1'b1,
                          half: (w_a[3:0] == 4'd0), carry: w_fi.carry};
            end
            aawf_pkg::OP_DAA: begin
                w_val = w_daa;
                w_fo  = '{zero: 1'b0, subtract: w_fi.subtract, half: 1'b0,
                          carry: (w_fi.subtract ? w_fi.carry : w_daa_hi)};
            end
            aawf_pkg::OP_RLC: begin
                w_val = {w_a[6:0], w_a[7]};
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: w_a[7]};
            end
            aawf_pkg::OP_RRC: begin
                w_val = {w_a[0], w_a[7:1]};
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: w_a[0]};
            end
            aawf_pkg::OP_RL: begin
                w_val = {w_a[6:0], w_fi.carry};
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: w_a[7]};
            end
            aawf_pkg::OP_RR: begin
                w_val = {w_fi.carry, w_a[7:1]};
                w_fo  = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: w_a[0]};
            end
            default: begin
                w_val = w_a;
                w_fo  = w_fi;
            end
        endcase
        // Zero flag from the computed value; pass-through keeps the old one.
        if (i_word.op != aawf_pkg::OP_PASS) begin
            w_fo.zero = (w_val == 8'd0);
        end
        // Compare leaves the accumulator as it was.
        w_res = (i_word.op == aawf_pkg::OP_CP) ? w_a : w_val;
    end

    assign o_word.result = w_res;
    assign o_word.flags  = w_fo;

endmodule

// ===== rtl/core/aawf_out_stage.sv =====
module aawf_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  aawf_pkg::t_out_word i_word,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output aawf_pkg::t_out_word o_word
);

    logic                r_valid;
    logic                n_valid;
    aawf_pkg::t_out_word r_word;

    // Take a new word when empty or when the current one leaves.
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the result word.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/core/accumulator_alu_with_flags.sv =====
// Channel  | Handshake                 | Word
// ---------+---------------------------+---------------------------------------------
// input    | i_in_valid / o_in_stall   | op, a_value, b_value, four flags in
// output   | o_out_valid / i_out_stall | result, four flags out
//
// Data path: operand register, then ALU logic into the result register.
// One word is taken every cycle while the output side is not stalled.
// The input stalls only when both registers are full and the output is stalled.
// Synchronous active-low reset empties both registers; data registers are not reset.
`include "accumulator_alu_with_flags_defines.svh"

module accumulator_alu_with_flags (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_op,
    input  logic [7:0] i_a_value,
    input  logic [7:0] i_b_value,
    input  logic       i_zero_in,
    input  logic       i_subtract_in,
    input  logic       i_half_in,
    input  logic       i_carry_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_result,
    output logic       o_zero_out,
    output logic       o_subtract_out,
    output logic       o_half_out,
    output logic       o_carry_out
);

    aawf_pkg::t_in_word  w_in_word;
    aawf_pkg::t_in_word  w_op_word;
    aawf_pkg::t_out_word w_alu_word;
    aawf_pkg::t_out_word w_res_word;
    logic                w_op_valid;
    logic                w_out_ready;

    // Pack the incoming word.
    assign w_in_word.op             = i_op;
    assign w_in_word.a_value        = i_a_value;
    assign w_in_word.b_value        = i_b_value;
    assign w_in_word.flags.zero     = i_zero_in;
    assign w_in_word.flags.subtract = i_subtract_in;
    assign w_in_word.flags.half     = i_half_in;
    assign w_in_word.flags.carry    = i_carry_in;

    aawf_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_word    (w_in_word),
        .i_advance (w_out_ready),
        .o_stall   (o_in_stall),
        .o_valid   (w_op_valid),
        .o_word    (w_op_word)
    );

    aawf_alu u_alu (
        .i_word (w_op_word),
        .o_word (w_alu_word)
    );

    aawf_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_op_valid),
        .i_word  (w_alu_word),
        .i_stall (i_out_stall),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_word  (w_res_word)
    );

    // Unpack the result word.
    assign o_result       = w_res_word.result;
    assign o_zero_out     = w_res_word.flags.zero;
    assign o_subtract_out = w_res_word.flags.subtract;
    assign o_half_out     = w_res_word.flags.half;
    assign o_carry_out    = w_res_word.flags.carry;

    `AAWF_ASSERT_IMP(a_stall_only_when_full, o_in_stall,
        w_op_valid && o_out_valid && i_out_stall, "input stalled with room left")
    `AAWF_ASSERT_NEXT(a_accept_fills_stage, i_in_valid && !o_in_stall,
        w_op_valid, "accepted word lost in operand stage")
    `AAWF_ASSERT_NEXT(a_advance_fills_out, w_op_valid && w_out_ready,
        o_out_valid, "operand word did not reach result register")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_IDLE     = 13;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 400;
    localparam int MAX_REPORTS  = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [3:0] i_op;
    logic [7:0] i_a_value;
    logic [7:0] i_b_value;
    logic       i_zero_in;
    logic       i_subtract_in;
    logic       i_half_in;
    logic       i_carry_in;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_result;
    logic       o_zero_out;
    logic       o_subtract_out;
    logic       o_half_out;
    logic       o_carry_out;

    aawf_pkg::t_out_word pending_results [$];
    int                  mismatch_count;
    bit                  idle_on;

    accumulator_alu_with_flags u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_a_value      (i_a_value),
        .i_b_value      (i_b_value),
        .i_zero_in      (i_zero_in),
        .i_subtract_in  (i_subtract_in),
        .i_half_in      (i_half_in),
        .i_carry_in     (i_carry_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result       (o_result),
        .o_zero_out     (o_zero_out),
        .o_subtract_out (o_subtract_out),
        .o_half_out     (o_half_out),
        .o_carry_out    (o_carry_out)
    );

    // Toggle the clock every half period
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Compute the result byte and new flags of one operation word
    function automatic aawf_pkg::t_out_word alu_predict(aawf_pkg::t_in_word w);
        aawf_pkg::t_out_word res;
        logic [8:0]          wide;
        logic [4:0]          nib;
        logic [7:0]          adj;
        logic                cin;
        logic                cy;
        res.result = w.a_value;
        res.flags  = w.flags;
        case (w.op)
            aawf_pkg::OP_ADD, aawf_pkg::OP_ADC: begin
                cin  = (w.op == aawf_pkg::OP_ADC) ? w.flags.carry : 1'b0;
                wide = {1'b0, w.a_value} + {1'b0, w.b_value} + {8'd0, cin};
                nib  = {1'b0, w.a_value[3:0]} + {1'b0, w.b_value[3:0]} + {4'd0, cin};
                res.result = wide[7:0];
                res.flags  = '{zero: wide[7:0] == 8'h00, subtract: 1'b0,
                               half: nib[4], carry: wide[8]};
            end
            aawf_pkg::OP_SUB, aawf_pkg::OP_SBC, aawf_pkg::OP_CP: begin
                // Bit 8 and bit 4 of the wrapped difference are the borrows
                cin  = (w.op == aawf_pkg::OP_SBC) ? w.flags.carry : 1'b0;
                wide = {1'b0, w.a_value} - {1'b0, w.b_value} - {8'd0, cin};
                nib  = {1'b0, w.a_value[3:0]} - {1'b0, w.b_value[3:0]} - {4'd0, cin};
                res.result = (w.op == aawf_pkg::OP_CP) ? w.a_value : wide[7:0];
                res.flags  = '{zero: wide[7:0] == 8'h00, subtract: 1'b1,
                               half: nib[4], carry: wide[8]};
            end
            aawf_pkg::OP_AND: begin
                res.result = w.a_value & w.b_value;
                res.flags  = '{zero: res.result == 8'h00, subtract: 1'b0,
                               half: 1'b1, carry: 1'b0};
            end
            aawf_pkg::OP_XOR: begin
                res.result = w.a_value ^ w.b_value;
                res.flags  = '{zero: res.result == 8'h00, subtract: 1'b0,
                               half: 1'b0, carry: 1'b0};
            end
            aawf_pkg::OP_OR: begin
                res.result = w.a_value | w.b_value;
                res.flags  = '{zero: res.result == 8'h00, subtract: 1'b0,
                               half: 1'b0, carry: 1'b0};
            end
            aawf_pkg::OP_INC: begin
                res.result = w.a_value + 8'h01;
                res.flags  = '{zero: res.result == 8'h00, subtract: 1'b0,
                               half: w.a_value[3:0] == aawf_pkg::NIBBLE_ALL,
                               carry: w.flags.carry};
            end
            aawf_pkg::OP_DEC: begin
                res.result = w.a_value - 8'h01;
                res.flags  = '{zero: res.result == 8'h00, subtract: 1'b1,
                               half: w.a_value[3:0] == 4'h0, carry: w.flags.carry};
            end
            aawf_pkg::OP_DAA: begin
                // Decide both adjustments from the original accumulator
                adj = w.a_value;
                cy  = w.flags.carry;
                if (!w.flags.subtract) begin
                    if (w.flags.carry || w.a_value > aawf_pkg::BCD_MAX) begin
                        adj = adj + aawf_pkg::BCD_HI_ADJ;
                        cy  = 1'b1;
                    end
                    if (w.flags.half || w.a_value[3:0] > aawf_pkg::DIGIT_MAX) begin
                        adj = adj + aawf_pkg::BCD_LO_ADJ;
                    end
                end else begin
                    if (w.flags.carry) begin
                        adj = adj - aawf_pkg::BCD_HI_ADJ;
                    end
                    if (w.flags.half) begin
                        adj = adj - aawf_pkg::BCD_LO_ADJ;
                    end
                end
                res.result = adj;
                res.flags  = '{zero: adj == 8'h00, subtract: w.flags.subtract,
                               half: 1'b0, carry: cy};
            end
            aawf_pkg::OP_RLC, aawf_pkg::OP_RRC, aawf_pkg::OP_RL, aawf_pkg::OP_RR: begin
                case (w.op)
                    aawf_pkg::OP_RLC: res.result = {w.a_value[6:0], w.a_value[7]};
                    aawf_pkg::OP_RRC: res.result = {w.a_value[0], w.a_value[7:1]};
                    aawf_pkg::OP_RL:  res.result = {w.a_value[6:0], w.flags.carry};
                    default:          res.result = {w.flags.carry, w.a_value[7:1]};
                endcase
                cy = (w.op == aawf_pkg::OP_RLC || w.op == aawf_pkg::OP_RL) ?
                     w.a_value[7] : w.a_value[0];
                res.flags = '{zero: res.result == 8'h00, subtract: 1'b0,
                              half: 1'b0, carry: cy};
            end
            default: begin
                res.result = w.a_value;
                res.flags  = w.flags;
            end
        endcase
        return res;
    endfunction

    // Pick an operand byte, leaning now and then on boundary values
    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 7) != 0) begin
            return 8'($urandom);
        end
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h0F;
            3:       return 8'hF0;
            4:       return 8'h99;
            default: return 8'h9A;
        endcase
    endfunction

    // Drive one word, hold it until taken, then queue its expected result.
    // Valid stays high after acceptance so back-to-back words need no toggle.
    task automatic send_word(input logic [3:0] op, input logic [7:0] a,
                             input logic [7:0] b, input logic [3:0] flags);
        aawf_pkg::t_in_word w;
        int                 gap;
        w.op      = op;
        w.a_value = a;
        w.b_value = b;
        w.flags   = flags;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= w.op;
        i_a_value     <= w.a_value;
        i_b_value     <= w.b_value;
        i_zero_in     <= w.flags.zero;
        i_subtract_in <= w.flags.subtract;
        i_half_in     <= w.flags.half;
        i_carry_in    <= w.flags.carry;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(alu_predict(w));
    endtask

    // Run each operation once with half-carry-prone operands, flags all set
    task automatic test_every_op();
        for (int k = 0; k < 16; k++) begin
            send_word(4'(k), 8'h0F, 8'hF1, 4'b1111);
        end
    endtask

    // Hit carries, borrows, zero results and the decimal adjust corners
    task automatic test_corner_cases();
        send_word(aawf_pkg::OP_ADD, 8'hFF, 8'h01, 4'b0000);
        send_word(aawf_pkg::OP_ADC, 8'h00, 8'h00, 4'b0001);
        send_word(aawf_pkg::OP_SBC, 8'h00, 8'hFF, 4'b0001);
        send_word(aawf_pkg::OP_CP,  8'h5A, 8'h5A, 4'b0000);
        send_word(aawf_pkg::OP_DAA, 8'h9A, 8'h00, 4'b0000);
        send_word(aawf_pkg::OP_DAA, 8'h00, 8'h00, 4'b0111);
        send_word(aawf_pkg::OP_RL,  8'h80, 8'h00, 4'b0000);
        send_word(aawf_pkg::OP_RR,  8'h01, 8'h00, 4'b0001);
        send_word(aawf_pkg::OP_INC, 8'hFF, 8'h00, 4'b0000);
        send_word(aawf_pkg::OP_DEC, 8'h01, 8'h00, 4'b0001);
        send_word(aawf_pkg::OP_PASS, 8'hA5, 8'h3C, 4'b0000);
    endtask

    // Fire random words, switching idling on and off in stretches
    task automatic test_random_ops();
        logic [3:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [3:0] flags;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 50 == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            op    = 4'($urandom_range(0, 15));
            a     = pick_operand();
            b     = pick_operand();
            flags = 4'($urandom);
            send_word(op, a, b, flags);
        end
    endtask

    // Stall the result side for a random count before each word while idling is on
    initial begin : result_sink
        int hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        aawf_pkg::t_out_word got;
        aawf_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.result = o_result;
            got.flags  = '{zero: o_zero_out, subtract: o_subtract_out,
                           half: o_half_out, carry: o_carry_out};
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("unexpected result word: result %02h znhc %04b",
                             got.result, got.flags);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.result !== want.result || got.flags.zero !== want.flags.zero ||
                    got.flags.subtract !== want.flags.subtract ||
                    got.flags.half !== want.flags.half ||
                    got.flags.carry !== want.flags.carry) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("mismatch: expected result %02h znhc %04b, got %02h znhc %04b",
                                 want.result, want.flags, got.result, got.flags);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when neither side moves a word for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Reset, run the tests, drain and report
    initial begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= 4'd0;
        i_a_value     <= 8'h00;
        i_b_value     <= 8'h00;
        i_zero_in     <= 1'b0;
        i_subtract_in <= 1'b0;
        i_half_in     <= 1'b0;
        i_carry_in    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_every_op();
        test_corner_cases();
        test_random_ops();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
